>>> src/lfu_pkg.sv
// lfu_pkg: shared types and constants of the frequency-ranked key-value cache
// no dependencies

package lfu_pkg;

    localparam int CAPACITY_DEFAULT    = 16;
    localparam int COUNT_WIDTH_DEFAULT = 16;
    localparam int KEY_WIDTH           = 32;
    localparam int VALUE_WIDTH         = 32;
    localparam int CAP_CFG_WIDTH       = 5;

    localparam logic [CAP_CFG_WIDTH-1:0] CAP_CFG_RESET = 5'd16;

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_WAIT,
        ST_DECIDE,
        ST_UPD,
        ST_UPD_WAIT,
        ST_DONE
    } lfu_state_t;

endpackage

>>> src/lfu_cache_with_lru_tiebreak.sv
// lfu_cache_with_lru_tiebreak: key-value cache, least-frequently-used eviction,
// least-recently-used among equal counts; entries live in one synchronous ram
// depends on lfu_pkg
//
// usage:
//   s_ channel carries one request item (command, lookup_key, write_value);
//   m_ channel returns one item per request (hit, read_value). both channels
//   use valid/ready. cfg_wr_en/cfg_wr_data write capacity_in_use; the user
//   must write it only while the block is idle (the block does not enforce it).
// timing:
//   every request sweeps the entry ram once (CAPACITY reads, one per cycle)
//   to find the key, a free slot and the eviction candidate. a request that
//   changes state sweeps it a second time, read-modify-write one entry per
//   cycle, to age recency ranks and write the touched slot. a get miss or a
//   put at zero capacity has no second sweep. one request is worked on at
//   a time.
// reset:
//   cache empty (valid bits and occupancy cleared), capacity_in_use = 16.
//   ram contents are not cleared; invalid entries are never used.
// stall:
//   the result waits in an output register; if it is still not taken when
//   the next result is ready, the block holds that request until it is.

module lfu_cache_with_lru_tiebreak #(
    parameter int CAPACITY    = lfu_pkg::CAPACITY_DEFAULT,
    parameter int COUNT_WIDTH = lfu_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [4:0]  cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_command,
    input  logic signed [31:0] s_lookup_key,
    input  logic signed [31:0] s_write_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_hit,
    output logic signed [31:0] m_read_value
);

    localparam int KW = lfu_pkg::KEY_WIDTH;
    localparam int VW = lfu_pkg::VALUE_WIDTH;
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int RW = IW;
    localparam int OW = $clog2(CAPACITY + 1);
    localparam int LW = (OW > lfu_pkg::CAP_CFG_WIDTH) ? OW : lfu_pkg::CAP_CFG_WIDTH;
    localparam int CNT_LSB = RW;
    localparam int VAL_LSB = RW + COUNT_WIDTH;
    localparam int KEY_LSB = RW + COUNT_WIDTH + VW;
    localparam int WW      = KEY_LSB + KW;
    localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);

    lfu_pkg::lfu_state_t state_reg, state_next;

    // entry ram: {key, value, count, rank}
    logic [WW-1:0] mem [CAPACITY];
    logic [WW-1:0] mem_q;
    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [WW-1:0] wr_data;

    logic [CAPACITY-1:0] valid_reg;
    logic [OW-1:0]       occ_reg;
    logic [4:0]          cap_cfg_reg;

    logic [IW-1:0] idx_reg;
    logic          pend_scan_reg;
    logic          pend_upd_reg;
    logic [IW-1:0] pend_idx_reg;

    logic          cmd_reg;
    logic [KW-1:0] key_reg;
    logic [VW-1:0] val_reg;

    logic                   match_found_reg;
    logic [IW-1:0]          match_idx_reg;
    logic [RW-1:0]          match_rank_reg;
    logic [VW-1:0]          match_value_reg;
    logic [COUNT_WIDTH-1:0] match_count_reg;
    logic                   free_found_reg;
    logic [IW-1:0]          free_idx_reg;
    logic                   vic_found_reg;
    logic [IW-1:0]          vic_idx_reg;
    logic [COUNT_WIDTH-1:0] vic_count_reg;
    logic [RW-1:0]          vic_rank_reg;

    logic [IW-1:0] slot_reg, slot_next;
    logic [WW-1:0] slot_word_reg, slot_word_next;
    logic [RW-1:0] old_rank_reg, old_rank_next;
    logic          age_all_reg, age_all_next;
    logic          do_upd_next;
    logic          set_valid_next;
    logic          res_hit_reg;
    logic [VW-1:0] res_val_reg, res_val_next;

    logic          m_valid_reg;
    logic          m_hit_reg;
    logic [VW-1:0] m_value_reg;

    logic                   q_valid;
    logic [KW-1:0]          q_key;
    logic [COUNT_WIDTH-1:0] q_count;
    logic [RW-1:0]          q_rank;
    logic [LW-1:0]          cap_ext;
    logic [LW-1:0]          cap_lim;
    logic [COUNT_WIDTH-1:0] cnt_inc;
    logic                   s_acc;
    logic                   out_free;

    assign s_acc    = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign q_valid = valid_reg[pend_idx_reg];
    assign q_key   = mem_q[KEY_LSB +: KW];
    assign q_count = mem_q[CNT_LSB +: COUNT_WIDTH];
    assign q_rank  = mem_q[RW-1:0];

    assign cap_ext = LW'(cap_cfg_reg);
    assign cap_lim = (cap_ext > LW'(CAPACITY)) ? LW'(CAPACITY) : cap_ext;
    assign cnt_inc = (&match_count_reg) ? match_count_reg
                                        : match_count_reg + COUNT_WIDTH'(1);

    // ram
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            mem_q <= mem[rd_addr];
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lfu_pkg::ST_IDLE: begin
                if (s_valid) state_next = lfu_pkg::ST_SCAN;
            end
            lfu_pkg::ST_SCAN: begin
                if (idx_reg == LAST_IDX) state_next = lfu_pkg::ST_SCAN_WAIT;
            end
            lfu_pkg::ST_SCAN_WAIT: state_next = lfu_pkg::ST_DECIDE;
            lfu_pkg::ST_DECIDE: begin
                state_next = do_upd_next ? lfu_pkg::ST_UPD : lfu_pkg::ST_DONE;
            end
            lfu_pkg::ST_UPD: begin
                if (idx_reg == LAST_IDX) state_next = lfu_pkg::ST_UPD_WAIT;
            end
            lfu_pkg::ST_UPD_WAIT: state_next = lfu_pkg::ST_DONE;
            lfu_pkg::ST_DONE: begin
                if (out_free) state_next = lfu_pkg::ST_IDLE;
            end
            default: state_next = lfu_pkg::ST_IDLE;
        endcase
    end

    // outputs of the state machine
    always_comb begin
        s_ready = 1'b0;
        rd_en   = 1'b0;
        unique case (state_reg)
            lfu_pkg::ST_IDLE: s_ready = 1'b1;
            lfu_pkg::ST_SCAN, lfu_pkg::ST_UPD: rd_en = 1'b1;
            default: begin
                s_ready = 1'b0;
                rd_en   = 1'b0;
            end
        endcase
    end
    assign rd_addr = idx_reg;

    // decide what the request does once the sweep is complete
    always_comb begin
        do_upd_next    = 1'b0;
        set_valid_next = 1'b0;
        age_all_next   = 1'b0;
        slot_next      = match_idx_reg;
        old_rank_next  = match_rank_reg;
        slot_word_next = {key_reg, val_reg, COUNT_WIDTH'(1), RW'(0)};
        if (cmd_reg == lfu_pkg::CMD_PUT) begin
            res_val_next = '0;
        end else begin
            res_val_next = match_found_reg ? match_value_reg : '1;
        end
        if (cmd_reg == lfu_pkg::CMD_GET) begin
            if (match_found_reg) begin
                do_upd_next    = 1'b1;
                slot_word_next = {key_reg, match_value_reg, cnt_inc, RW'(0)};
            end
        end else if (cap_lim != '0) begin
            priority if (match_found_reg) begin
                do_upd_next    = 1'b1;
                slot_word_next = {key_reg, val_reg, cnt_inc, RW'(0)};
            end else if (LW'(occ_reg) < cap_lim && free_found_reg) begin
                // fill a free slot, every present entry ages
                do_upd_next    = 1'b1;
                set_valid_next = 1'b1;
                age_all_next   = 1'b1;
                slot_next      = free_idx_reg;
            end else if (vic_found_reg) begin
                do_upd_next   = 1'b1;
                slot_next     = vic_idx_reg;
                old_rank_next = vic_rank_reg;
            end else begin
                do_upd_next = 1'b0;
            end
        end
    end

    // write-back during the update sweep
    always_comb begin
        wr_en   = pend_upd_reg;
        wr_addr = pend_idx_reg;
        wr_data = mem_q;
        if (pend_idx_reg == slot_reg) begin
            wr_data = slot_word_reg;
        end else if (q_valid && (age_all_reg || q_rank < old_rank_reg)) begin
            wr_data = {mem_q[WW-1:RW], q_rank + RW'(1)};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= lfu_pkg::ST_IDLE;
            valid_reg     <= '0;
            occ_reg       <= '0;
            cap_cfg_reg   <= lfu_pkg::CAP_CFG_RESET;
            idx_reg       <= '0;
            pend_scan_reg <= 1'b0;
            pend_upd_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            pend_scan_reg <= (state_reg == lfu_pkg::ST_SCAN);
            pend_upd_reg  <= (state_reg == lfu_pkg::ST_UPD);
            if (cfg_wr_en) begin
                cap_cfg_reg <= cfg_wr_data;
            end
            if (state_reg == lfu_pkg::ST_SCAN || state_reg == lfu_pkg::ST_UPD) begin
                idx_reg <= (idx_reg == LAST_IDX) ? '0 : idx_reg + IW'(1);
            end
            if (state_reg == lfu_pkg::ST_DECIDE && set_valid_next) begin
                valid_reg[slot_next] <= 1'b1;
                occ_reg              <= occ_reg + OW'(1);
            end
            if (state_reg == lfu_pkg::ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        pend_idx_reg <= idx_reg;
        if (s_acc) begin
            cmd_reg         <= s_command;
            key_reg         <= s_lookup_key;
            val_reg         <= s_write_value;
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            vic_found_reg   <= 1'b0;
        end
        if (pend_scan_reg) begin
            if (q_valid && q_key == key_reg && !match_found_reg) begin
                match_found_reg <= 1'b1;
                match_idx_reg   <= pend_idx_reg;
                match_rank_reg  <= q_rank;
                match_value_reg <= mem_q[VAL_LSB +: VW];
                match_count_reg <= q_count;
            end
            if (!q_valid && !free_found_reg) begin
                free_found_reg <= 1'b1;
                free_idx_reg   <= pend_idx_reg;
            end
            // lowest count, then oldest
            if (q_valid && (!vic_found_reg || q_count < vic_count_reg ||
                            (q_count == vic_count_reg && q_rank > vic_rank_reg))) begin
                vic_found_reg <= 1'b1;
                vic_idx_reg   <= pend_idx_reg;
                vic_count_reg <= q_count;
                vic_rank_reg  <= q_rank;
            end
        end
        if (state_reg == lfu_pkg::ST_DECIDE) begin
            slot_reg      <= slot_next;
            slot_word_reg <= slot_word_next;
            old_rank_reg  <= old_rank_next;
            age_all_reg   <= age_all_next;
            res_hit_reg   <= match_found_reg;
            res_val_reg   <= res_val_next;
        end
        if (state_reg == lfu_pkg::ST_DONE && out_free) begin
            m_hit_reg   <= res_hit_reg;
            m_value_reg <= res_val_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_hit        = m_hit_reg;
    assign m_read_value = m_value_reg;

    a_occ_matches_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(valid_reg) == int'(occ_reg))
        else $error("occupancy out of step with valid bits");

    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(occ_reg) <= CAPACITY)
        else $error("occupancy above capacity");

    a_no_write_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> !pend_scan_reg && !rd_en || state_reg == lfu_pkg::ST_UPD)
        else $error("ram write outside update sweep");

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == lfu_pkg::ST_DONE && m_valid_reg && !m_ready)
        |=> state_reg == lfu_pkg::ST_DONE)
        else $error("result dropped while receiver stalled");

endmodule
